// ===== src/fau_pkg.sv =====
// shared types and constants for the fraction arithmetic unit
`timescale 1ns / 1ps

package fau_pkg;

    // width of the result numerator and denominator
    localparam int RES_BITS = 32;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_EQ  = 3'd4,
        MODE_GT  = 3'd5,
        MODE_RED = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } t_state;

endpackage

// ===== src/fau_in_if.sv =====
// operand channel of the fraction arithmetic unit
`timescale 1ns / 1ps

interface fau_in_if #(
    parameter int OPERAND_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic [2:0]                     mode;
    logic signed [OPERAND_BITS-1:0] a_num;
    logic [OPERAND_BITS-2:0]        a_den;
    logic signed [OPERAND_BITS-1:0] b_num;
    logic [OPERAND_BITS-2:0]        b_den;

    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== src/fau_out_if.sv =====
// result channel of the fraction arithmetic unit
`timescale 1ns / 1ps

interface fau_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fau_pkg::RES_BITS-1:0] res_num;
    logic signed [fau_pkg::RES_BITS-1:0] res_den;
    logic                                truth;
    logic                                zero_den;

    modport source (output valid, res_num, res_den, truth, zero_den, input ready);
    modport sink (input valid, res_num, res_den, truth, zero_den, output ready);
endinterface

// ===== src/fraction_arithmetic_unit.sv =====
// fraction arithmetic unit: shared gcd step, restoring divider and multiplier under a sequencer
// equal, reserved and no-gcd add/subtract/reduce go straight to the finish state; mul, div, greater use the multiplier
// add/subtract with unequal denominators and reduce: binary gcd, then two restoring divides,
// then the multiplier steps for add/subtract, while reduce finishes after the divides
// one item at a time; the next item is taken while a finished result waits at the output
// synchronous active-low reset clears the sequencer and the output valid
`timescale 1ns / 1ps

module fraction_arithmetic_unit #(
    parameter int OPERAND_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fau_in_if.sink       i_in,
    fau_out_if.source    o_out
);

    localparam int W  = OPERAND_BITS;
    localparam int RB = fau_pkg::RES_BITS;
    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

    fau_pkg::t_state r_state, n_state;

    fau_pkg::t_mode        r_mode, n_mode;
    logic signed [W-1:0]   r_an, n_an;
    logic [W-2:0]          r_ad, n_ad;
    logic signed [W-1:0]   r_bn, n_bn;
    logic [W-2:0]          r_bd, n_bd;

    logic [W-1:0]          r_x, n_x;
    logic [W-1:0]          r_y, n_y;
    logic [KW-1:0]         r_k, n_k;
    logic [W-1:0]          r_g, n_g;
    logic [W-1:0]          r_rem, n_rem;
    logic [W-1:0]          r_quo, n_quo;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_dsel, n_dsel;
    logic [W-1:0]          r_q0, n_q0;
    logic [W-1:0]          r_q1, n_q1;
    logic [1:0]            r_step, n_step;
    logic signed [2*W-1:0] r_prod, n_prod;
    logic signed [2*W-1:0] r_lhs, n_lhs;
    logic [RB-1:0]         r_rn, n_rn;
    logic [RB-1:0]         r_rd, n_rd;
    logic                  r_truth, n_truth;
    logic                  r_zd, n_zd;

    logic                  r_ovalid;
    logic [RB-1:0]         r_o_num;
    logic [RB-1:0]         r_o_den;
    logic                  r_o_truth;
    logic                  r_o_zd;

    fau_pkg::t_mode        w_in_mode;
    logic                  w_accept;
    logic                  w_opzero;
    logic                  w_direct;
    logic [W-1:0]          w_in_mag;
    logic [W-1:0]          w_mag;
    logic                  w_gcd_done;
    logic [W-1:0]          w_gsrc;
    logic [W:0]            w_trial;
    logic                  w_ge;
    logic [W-1:0]          w_div_quo;
    logic                  w_div_last;
    logic [W-1:0]          w_dividend0;
    logic [W-1:0]          w_dividend1;
    logic                  w_is_addsub;
    logic                  w_mul_last;
    logic signed [W-1:0]   w_ad_s;
    logic signed [W-1:0]   w_bd_s;
    logic signed [W-1:0]   w_q0_s;
    logic signed [W-1:0]   w_q1_s;
    logic signed [W-1:0]   w_ma;
    logic signed [W-1:0]   w_mb;
    logic                  w_fin_load;

    assign w_in_mode = fau_pkg::t_mode'(i_in.mode);
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_opzero  = (i_in.a_den == '0) || (i_in.b_den == '0);
    assign w_in_mag  = i_in.a_num[W-1] ? $unsigned(-i_in.a_num) : $unsigned(i_in.a_num);
    assign w_mag     = r_an[W-1] ? $unsigned(-r_an) : $unsigned(r_an);

    // items that finish without any iteration
    always_comb begin
        case (w_in_mode)
            fau_pkg::MODE_ADD, fau_pkg::MODE_SUB: begin
                w_direct = w_opzero || (i_in.a_den == i_in.b_den);
            end
            fau_pkg::MODE_MUL, fau_pkg::MODE_DIV, fau_pkg::MODE_GT: begin
                w_direct = 1'b0;
            end
            fau_pkg::MODE_RED: begin
                w_direct = (i_in.a_den == '0);
            end
            default: begin
                w_direct = 1'b1;
            end
        endcase
    end

    // binary gcd and restoring divider status
    assign w_gcd_done = (r_x == '0) || (r_y == '0);
    assign w_gsrc     = (r_x == '0) ? r_y : r_x;
    assign w_trial    = {r_rem, r_quo[W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_g});
    assign w_div_quo  = {r_quo[W-2:0], w_ge};
    assign w_div_last = (r_cnt == CNT_LAST);
    assign w_dividend0 = (r_mode == fau_pkg::MODE_RED) ? w_mag : {1'b0, r_ad};
    assign w_dividend1 = (r_mode == fau_pkg::MODE_RED) ? {1'b0, r_ad} : {1'b0, r_bd};

    // shared multiplier operand selection
    assign w_is_addsub = (r_mode inside {fau_pkg::MODE_ADD, fau_pkg::MODE_SUB});
    assign w_mul_last  = (r_step == (w_is_addsub ? 2'd3 : 2'd2));
    assign w_ad_s = {1'b0, r_ad};
    assign w_bd_s = {1'b0, r_bd};
    assign w_q0_s = r_q0;
    assign w_q1_s = r_q1;

    always_comb begin
        w_ma = r_an;
        w_mb = w_bd_s;
        case (r_mode)
            fau_pkg::MODE_ADD, fau_pkg::MODE_SUB: begin
                case (r_step)
                    2'd0:    begin w_ma = w_q0_s; w_mb = w_bd_s; end
                    2'd1:    begin w_ma = r_an;   w_mb = w_q1_s; end
                    default: begin w_ma = r_bn;   w_mb = w_q0_s; end
                endcase
            end
            fau_pkg::MODE_MUL: begin
                if (r_step == 2'd0) begin
                    w_ma = r_an;
                    w_mb = r_bn;
                end else begin
                    w_ma = w_ad_s;
                    w_mb = w_bd_s;
                end
            end
            fau_pkg::MODE_DIV, fau_pkg::MODE_GT: begin
                if (r_step == 2'd0) begin
                    w_ma = r_an;
                    w_mb = w_bd_s;
                end else begin
                    w_ma = r_bn;
                    w_mb = w_ad_s;
                end
            end
            default: begin
                w_ma = r_an;
                w_mb = w_bd_s;
            end
        endcase
    end

    assign w_fin_load = (r_state == fau_pkg::ST_FIN) && (!r_ovalid || o_out.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fau_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if (w_direct) begin
                        n_state = fau_pkg::ST_FIN;
                    end else if (w_in_mode inside {fau_pkg::MODE_MUL, fau_pkg::MODE_DIV,
                                                   fau_pkg::MODE_GT}) begin
                        n_state = fau_pkg::ST_MUL;
                    end else begin
                        n_state = fau_pkg::ST_GCD;
                    end
                end
            end
            fau_pkg::ST_GCD: begin
                if (w_gcd_done) begin
                    n_state = fau_pkg::ST_DIV;
                end
            end
            fau_pkg::ST_DIV: begin
                if (w_div_last && r_dsel) begin
                    n_state = (r_mode == fau_pkg::MODE_RED) ? fau_pkg::ST_FIN
                                                            : fau_pkg::ST_MUL;
                end
            end
            fau_pkg::ST_MUL: begin
                if (w_mul_last) begin
                    n_state = fau_pkg::ST_FIN;
                end
            end
            fau_pkg::ST_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = fau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fau_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_mode  = r_mode;
        n_an    = r_an;
        n_ad    = r_ad;
        n_bn    = r_bn;
        n_bd    = r_bd;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_g     = r_g;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_dsel  = r_dsel;
        n_q0    = r_q0;
        n_q1    = r_q1;
        n_step  = r_step;
        n_prod  = r_prod;
        n_lhs   = r_lhs;
        n_rn    = r_rn;
        n_rd    = r_rd;
        n_truth = r_truth;
        n_zd    = r_zd;
        case (r_state)
            fau_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_mode  = w_in_mode;
                    n_an    = i_in.a_num;
                    n_ad    = i_in.a_den;
                    n_bn    = i_in.b_num;
                    n_bd    = i_in.b_den;
                    n_k     = '0;
                    n_step  = '0;
                    n_rn    = '0;
                    n_rd    = RB'(1);
                    n_truth = 1'b0;
                    n_zd    = w_opzero;
                    n_x     = {1'b0, i_in.a_den};
                    n_y     = {1'b0, i_in.b_den};
                    case (w_in_mode)
                        fau_pkg::MODE_ADD, fau_pkg::MODE_SUB: begin
                            if (w_opzero) begin
                                n_rd = '0;
                            end else if (i_in.a_den == i_in.b_den) begin
                                n_rd = RB'(i_in.a_den);
                                n_rn = (w_in_mode == fau_pkg::MODE_ADD)
                                     ? RB'(i_in.a_num) + RB'(i_in.b_num)
                                     : RB'(i_in.a_num) - RB'(i_in.b_num);
                            end
                        end
                        fau_pkg::MODE_EQ: begin
                            n_truth = (i_in.a_num == i_in.b_num) && (i_in.a_den == i_in.b_den);
                        end
                        fau_pkg::MODE_RED: begin
                            n_zd = (i_in.a_den == '0);
                            n_x  = w_in_mag;
                            n_y  = {1'b0, i_in.a_den};
                            if (i_in.a_den == '0) begin
                                n_rn = RB'(i_in.a_num);
                                n_rd = '0;
                            end
                        end
                        fau_pkg::MODE_MUL, fau_pkg::MODE_DIV, fau_pkg::MODE_GT: begin
                            n_rd = RB'(1);
                        end
                        default: begin
                            n_zd = 1'b0;
                        end
                    endcase
                end
            end
            fau_pkg::ST_GCD: begin
                if (w_gcd_done) begin
                    n_g    = w_gsrc << r_k;
                    n_quo  = w_dividend0;
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_dsel = 1'b0;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = r_x - r_y;
                end else begin
                    n_y = r_y - r_x;
                end
            end
            fau_pkg::ST_DIV: begin
                n_rem = w_ge ? W'(w_trial - {1'b0, r_g}) : w_trial[W-1:0];
                n_quo = w_div_quo;
                n_cnt = r_cnt + 1'b1;
                if (w_div_last) begin
                    if (!r_dsel) begin
                        n_q0   = w_div_quo;
                        n_quo  = w_dividend1;
                        n_rem  = '0;
                        n_cnt  = '0;
                        n_dsel = 1'b1;
                    end else begin
                        n_q1   = w_div_quo;
                        n_step = '0;
                        // sign goes back onto the reduced numerator
                        n_rn   = r_an[W-1] ? RB'(0) - RB'(r_q0) : RB'(r_q0);
                        n_rd   = RB'(w_div_quo);
                    end
                end
            end
            fau_pkg::ST_MUL: begin
                n_prod = w_ma * w_mb;
                n_step = r_step + 1'b1;
                // consume the product registered in the previous step
                if (r_step != 2'd0) begin
                    case (r_mode)
                        fau_pkg::MODE_ADD, fau_pkg::MODE_SUB: begin
                            case (r_step)
                                2'd1: n_rd = RB'(r_prod);
                                2'd2: n_rn = RB'(r_prod);
                                default: begin
                                    n_rn = (r_mode == fau_pkg::MODE_ADD) ? r_rn + RB'(r_prod)
                                                                         : r_rn - RB'(r_prod);
                                end
                            endcase
                        end
                        fau_pkg::MODE_MUL: begin
                            if (r_step == 2'd1) begin
                                n_rn = RB'(r_prod);
                            end else begin
                                n_rd = RB'(r_prod);
                            end
                        end
                        fau_pkg::MODE_DIV: begin
                            if (r_step == 2'd1) begin
                                n_rn = RB'(r_prod);
                            end else begin
                                n_rd = RB'(r_prod);
                                n_zd = r_zd || (RB'(r_prod) == '0);
                            end
                        end
                        fau_pkg::MODE_GT: begin
                            if (r_step == 2'd1) begin
                                n_lhs = r_prod;
                            end else begin
                                n_truth = (r_lhs > r_prod);
                            end
                        end
                        default: begin
                            n_lhs = r_lhs;
                        end
                    endcase
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fau_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_an    <= n_an;
        r_ad    <= n_ad;
        r_bn    <= n_bn;
        r_bd    <= n_bd;
        r_x     <= n_x;
        r_y     <= n_y;
        r_k     <= n_k;
        r_g     <= n_g;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_dsel  <= n_dsel;
        r_q0    <= n_q0;
        r_q1    <= n_q1;
        r_step  <= n_step;
        r_prod  <= n_prod;
        r_lhs   <= n_lhs;
        r_rn    <= n_rn;
        r_rd    <= n_rd;
        r_truth <= n_truth;
        r_zd    <= n_zd;
        if (w_fin_load) begin
            r_o_num   <= r_rn;
            r_o_den   <= r_rd;
            r_o_truth <= r_truth;
            r_o_zd    <= r_zd;
        end
    end

    assign i_in.ready     = (r_state == fau_pkg::ST_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.res_num  = r_o_num;
    assign o_out.res_den  = r_o_den;
    assign o_out.truth    = r_o_truth;
    assign o_out.zero_den = r_o_zd;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != fau_pkg::ST_IDLE))
        else $error("accepted item did not start work");

    a_gcd_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fau_pkg::ST_GCD) |-> (r_x != '0 || r_y != '0))
        else $error("gcd step with both operands zero");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fau_pkg::ST_DIV) |-> (r_g != '0))
        else $error("divide by zero gcd");

    a_fin_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_load |=> (o_out.valid && r_state != fau_pkg::ST_FIN))
        else $error("finished item not presented");

endmodule

// ===== sim/fraction_arithmetic_unit_tb.sv =====
// self-checking testbench for the fraction arithmetic unit: directed table, then random items
`timescale 1ns / 1ps

module fraction_arithmetic_unit_tb;

    localparam int OPERAND_BITS = 16;
    localparam logic [2:0] MODE_RESERVED = 3'd7;

    localparam int NUM_DIRECTED = 25;
    localparam int TOTAL_ITEMS = 1900;
    localparam int TAIL_ITEMS = 150;
    localparam int HOLDOFF_AT = 700;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0]                     mode;
        logic signed [OPERAND_BITS-1:0] a_num;
        logic [OPERAND_BITS-2:0]        a_den;
        logic signed [OPERAND_BITS-1:0] b_num;
        logic [OPERAND_BITS-2:0]        b_den;
    } t_fraction_pair;

    typedef struct packed {
        logic signed [fau_pkg::RES_BITS-1:0] res_num;
        logic signed [fau_pkg::RES_BITS-1:0] res_den;
        logic                                truth;
        logic                                zero_den;
    } t_fraction_result;

    typedef struct packed {
        t_fraction_pair   pair;
        logic             typed;
        t_fraction_result want;
    } t_directed_row;

    // rows with typed = 0 are checked against the predictor
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{fau_pkg::MODE_ADD, 1, 2, 1, 3}, 1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_ADD, 1, 4, 1, 4}, 1'b1, '{2, 4, 1'b0, 1'b0}},
        '{'{MODE_RESERVED, 9, 4, 3, 0}, 1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_ADD, 1, 0, 1, 3}, 1'b1, '{0, 0, 1'b0, 1'b1}},
        '{'{fau_pkg::MODE_SUB, 1, 3, 1, 0}, 1'b1, '{0, 0, 1'b0, 1'b1}},
        '{'{fau_pkg::MODE_ADD, -32768, 32767, 32767, 32766}, 1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_SUB, 32767, 1, -32768, 1}, 1'b1, '{65535, 1, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_MUL, -32768, 32767, -32768, 32767}, 1'b1,
          '{1073741824, 1073676289, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_MUL, 3, 0, 5, 7}, 1'b1, '{15, 0, 1'b0, 1'b1}},
        '{'{fau_pkg::MODE_DIV, 3, 4, 5, 7}, 1'b0, '{0, 0, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_DIV, 1, 2, -3, 5}, 1'b1, '{5, -6, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_DIV, 7, 3, 0, 5}, 1'b1, '{35, 0, 1'b0, 1'b1}},
        '{'{fau_pkg::MODE_DIV, 32767, 32767, -32768, 32767}, 1'b1,
          '{1073676289, -1073709056, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_EQ, 3, 4, 3, 4}, 1'b1, '{0, 1, 1'b1, 1'b0}},
        '{'{fau_pkg::MODE_EQ, 1, 2, 2, 4}, 1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_EQ, 5, 0, 5, 0}, 1'b1, '{0, 1, 1'b1, 1'b1}},
        '{'{fau_pkg::MODE_GT, 1, 3, 1, 2}, 1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_GT, 32767, 1, -32768, 1}, 1'b1, '{0, 1, 1'b1, 1'b0}},
        '{'{fau_pkg::MODE_GT, 2, 4, 1, 2}, 1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_GT, 1, 0, -1, 0}, 1'b1, '{0, 1, 1'b0, 1'b1}},
        '{'{fau_pkg::MODE_RED, 6, 8, 0, 1}, 1'b1, '{3, 4, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_RED, -6, 8, 0, 1}, 1'b1, '{-3, 4, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_RED, 0, 5, 0, 1}, 1'b1, '{0, 1, 1'b0, 1'b0}},
        '{'{fau_pkg::MODE_RED, 5, 0, 0, 7}, 1'b1, '{5, 0, 1'b0, 1'b1}},
        '{'{fau_pkg::MODE_RED, -32768, 32767, 0, 1}, 1'b1, '{-32768, 32767, 1'b0, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    fau_in_if #(.OPERAND_BITS(OPERAND_BITS)) op_ch ();
    fau_out_if res_ch ();

    t_fraction_result pending_fractions [$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    bit holdoff_request = 1'b0;
    bit tail_part = 1'b0;

    fraction_arithmetic_unit #(.OPERAND_BITS(OPERAND_BITS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction_result predict_fraction(t_fraction_pair p);
        t_fraction_result r;
        longint an, bn, ad, bd, lcd, mag, quot;
        longint unsigned g;
        bit zero_op;
        an = p.a_num;
        bn = p.b_num;
        ad = p.a_den;
        bd = p.b_den;
        zero_op = (ad == 0) || (bd == 0);
        r = '{0, 1, 1'b0, 1'b0};
        case (p.mode)
            fau_pkg::MODE_ADD, fau_pkg::MODE_SUB: begin
                if (zero_op) begin
                    r = '{0, 0, 1'b0, 1'b1};
                end else begin
                    // equal denominators are kept, else scale both to the lcm
                    if (ad == bd) begin
                        lcd = ad;
                    end else begin
                        g = gcd_of(ad, bd);
                        lcd = (ad / longint'(g)) * bd;
                        an = an * (lcd / ad);
                        bn = bn * (lcd / bd);
                    end
                    r.res_num = (p.mode == fau_pkg::MODE_ADD) ? 32'(an + bn) : 32'(an - bn);
                    r.res_den = 32'(lcd);
                end
            end
            fau_pkg::MODE_MUL: begin
                r.res_num = 32'(an * bn);
                r.res_den = 32'(ad * bd);
                r.zero_den = zero_op;
            end
            fau_pkg::MODE_DIV: begin
                r.res_num = 32'(an * bd);
                r.res_den = 32'(ad * bn);
                r.zero_den = zero_op || (r.res_den == 0);
            end
            fau_pkg::MODE_EQ: begin
                r.truth = (an == bn) && (ad == bd);
                r.zero_den = zero_op;
            end
            fau_pkg::MODE_GT: begin
                r.truth = (an * bd) > (bn * ad);
                r.zero_den = zero_op;
            end
            fau_pkg::MODE_RED: begin
                if (ad == 0) begin
                    r = '{32'(an), 0, 1'b0, 1'b1};
                end else begin
                    mag = (an < 0) ? -an : an;
                    g = gcd_of(mag, ad);
                    quot = mag / longint'(g);
                    r.res_num = (an < 0) ? 32'(-quot) : 32'(quot);
                    r.res_den = 32'(ad / longint'(g));
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endtask

    // sender: directed table, then random items
    initial begin
        t_fraction_pair item;
        logic typed;
        int unsigned roll;
        op_ch.valid = 1'b0;
        op_ch.mode = fau_pkg::MODE_ADD;
        op_ch.a_num = '0;
        op_ch.a_den = '0;
        op_ch.b_num = '0;
        op_ch.b_den = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int idx = 0; idx < TOTAL_ITEMS; idx++) begin
            typed = 1'b0;
            if (idx < NUM_DIRECTED) begin
                item = DIRECTED_ROWS[idx].pair;
                typed = DIRECTED_ROWS[idx].typed;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 18) item.mode = fau_pkg::MODE_ADD;
                else if (roll < 36) item.mode = fau_pkg::MODE_SUB;
                else if (roll < 48) item.mode = fau_pkg::MODE_MUL;
                else if (roll < 60) item.mode = fau_pkg::MODE_DIV;
                else if (roll < 70) item.mode = fau_pkg::MODE_EQ;
                else if (roll < 82) item.mode = fau_pkg::MODE_GT;
                else if (roll < 98) item.mode = fau_pkg::MODE_RED;
                else item.mode = MODE_RESERVED;
                item.a_num = 16'($urandom);
                item.a_den = 15'($urandom);
                item.b_num = 16'($urandom);
                item.b_den = 15'($urandom);
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // small operands give common factors and short gcd runs
                        item.a_num = 16'(int'($urandom_range(0, 48)) - 24);
                        item.a_den = 15'($urandom_range(1, 24));
                        item.b_num = 16'(int'($urandom_range(0, 48)) - 24);
                        item.b_den = 15'($urandom_range(1, 24));
                    end
                    2: begin
                        item.b_num = item.a_num;
                        item.b_den = item.a_den;
                    end
                    3: item.b_den = item.a_den;
                    4: begin
                        if ($urandom_range(0, 1)) item.a_den = '0;
                        else item.b_den = '0;
                    end
                    5: begin
                        item.a_num = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                        item.a_den = $urandom_range(0, 1) ? 15'h7fff : 15'd1;
                        item.b_num = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                        item.b_den = $urandom_range(0, 1) ? 15'h7fff : 15'd1;
                    end
                    default: begin
                    end
                endcase
            end
            if (idx == HOLDOFF_AT) holdoff_request = 1'b1;
            if (idx == TOTAL_ITEMS - TAIL_ITEMS) tail_part = 1'b1;
            if (!tail_part && $urandom_range(0, 3) == 0) begin
                op_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            op_ch.valid <= 1'b1;
            op_ch.mode <= item.mode;
            op_ch.a_num <= item.a_num;
            op_ch.a_den <= item.a_den;
            op_ch.b_num <= item.b_num;
            op_ch.b_den <= item.b_den;
            do @(posedge i_clk); while (!op_ch.ready);
            if (typed) pending_fractions.push_back(DIRECTED_ROWS[idx].want);
            else pending_fractions.push_back(predict_fraction(item));
        end
        op_ch.valid <= 1'b0;
        while (pending_fractions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // receiver: random stall bursts, one long hold-off to back up the input
    initial begin
        bit holdoff_done;
        holdoff_done = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holdoff_request && !holdoff_done) begin
                holdoff_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else if (!tail_part && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_fraction_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_fractions.size() == 0) begin
                note_mismatch($sformatf("unexpected item %0d/%0d truth %0b zero_den %0b",
                    res_ch.res_num, res_ch.res_den, res_ch.truth, res_ch.zero_den));
            end else begin
                want = pending_fractions.pop_front();
                if (res_ch.res_num !== want.res_num || res_ch.res_den !== want.res_den ||
                    res_ch.truth !== want.truth || res_ch.zero_den !== want.zero_den) begin
                    note_mismatch($sformatf(
                        "got %0d/%0d truth %0b zero_den %0b, want %0d/%0d truth %0b zero_den %0b",
                        res_ch.res_num, res_ch.res_den, res_ch.truth, res_ch.zero_den,
                        want.res_num, want.res_den, want.truth, want.zero_den));
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
src/fau_pkg.sv
src/fau_in_if.sv
src/fau_out_if.sv
src/fraction_arithmetic_unit.sv
sim/fraction_arithmetic_unit_tb.sv
